/* hw/rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// Circular deque package
// Shared constants, request codes, the controller-to-datapath command bundle
// and the ring pointer step functions.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int REQ_W = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INS_REAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_REAR  = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [VAL_W-1:0] t_val;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;    // carry out the request on the input ports this edge
        logic rd_en;   // read the slots at head and tail
    } t_dp_cmd;

    // Move an index forward, wrapping at the last usable slot.
    function automatic t_idx step_fwd(input t_idx idx, input t_cnt lim);
        t_idx res;
        if (CNT_W'(idx) >= lim - t_cnt'(1)) begin
            res = '0;
        end else begin
            res = idx + t_idx'(1);
        end
        return res;
    endfunction

    // Move an index back, wrapping from slot zero to the last usable slot.
    function automatic t_idx step_back(input t_idx idx, input t_cnt lim);
        t_idx res;
        if (idx == '0) begin
            res = IDX_W'(lim - t_cnt'(1));
        end else begin
            res = idx - t_idx'(1);
        end
        return res;
    endfunction

endpackage

/* hw/rtl/cdq_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hw/rtl/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences each request: execute on acceptance, read the ends, respond.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_strobe,
    output cdq_pkg::t_dp_cmd o_cmd
);

    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_strobe;
    logic   accept;

    assign accept = start && !r_busy;

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_READ : S_IDLE;
            S_READ:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state != S_IDLE);
            r_strobe <= (n_state == S_RESP);
        end
    end

    assign busy        = r_busy;
    assign o_strobe    = r_strobe;
    assign o_cmd.exec  = accept;
    assign o_cmd.rd_en = (r_state == S_READ);

endmodule

/* hw/rtl/cdq_datapath.sv */
// ----------------------------------------------------------------------------
// Circular deque datapath
// Holds capacity, head, tail and count, and the slot memory; forms the result.
// ----------------------------------------------------------------------------
module cdq_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cdq_pkg::t_dp_cmd      i_cmd,
    input  logic                  i_cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic [cdq_pkg::REQ_W-1:0] i_req_type,
    input  logic signed [cdq_pkg::VAL_W-1:0] i_value,
    output logic                  o_accepted,
    output logic signed [cdq_pkg::VAL_W-1:0] o_front_value,
    output logic signed [cdq_pkg::VAL_W-1:0] o_rear_value,
    output logic                  o_empty_flag,
    output logic                  o_full_flag,
    output logic [cdq_pkg::CNT_W-1:0] o_occupancy
);

    import cdq_pkg::*;

    t_cnt r_cap;
    t_idx r_head;
    t_idx r_tail;
    t_cnt r_count;
    logic r_accepted;

    t_cnt lim;
    logic is_full;
    logic is_empty;
    logic is_insert;
    logic ok;
    t_idx n_head;
    t_idx n_tail;
    t_cnt n_count;
    logic wr_en;
    t_idx wr_addr;
    t_val front_q;
    t_val rear_q;

    // Out-of-range capacity is clamped into 1..DEPTH.
    always_comb begin
        if (r_cap == '0) begin
            lim = t_cnt'(1);
        end else if (r_cap > CNT_W'(DEPTH)) begin
            lim = CNT_W'(DEPTH);
        end else begin
            lim = r_cap;
        end
    end

    assign is_full   = (r_count >= lim);
    assign is_empty  = (r_count == '0);
    assign is_insert = (i_req_type == REQ_INS_FRONT) || (i_req_type == REQ_INS_REAR);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        wr_en   = 1'b0;
        wr_addr = r_head;
        ok      = 1'b0;
        if (is_insert) begin
            if (!is_full) begin
                ok      = 1'b1;
                wr_en   = i_cmd.exec;
                n_count = r_count + t_cnt'(1);
                if (is_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    wr_addr = '0;
                end else if (i_req_type == REQ_INS_FRONT) begin
                    n_head  = step_back(r_head, lim);
                    wr_addr = n_head;
                end else begin
                    n_tail  = step_fwd(r_tail, lim);
                    wr_addr = n_tail;
                end
            end
        end else if (!is_empty) begin
            ok      = 1'b1;
            n_count = r_count - t_cnt'(1);
            if (i_req_type == REQ_DEL_FRONT) begin
                n_head = step_fwd(r_head, lim);
            end else begin
                n_tail = step_back(r_tail, lim);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_accepted <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_head     <= n_head;
                r_tail     <= n_tail;
                r_count    <= n_count;
                r_accepted <= ok;
            end
        end
    end

    cdq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (i_value),
        .i_re      (i_cmd.rd_en),
        .i_raddr_a (r_head),
        .i_raddr_b (r_tail),
        .o_rdata_a (front_q),
        .o_rdata_b (rear_q)
    );

    assign o_accepted    = r_accepted;
    assign o_front_value = is_empty ? '1 : front_q;
    assign o_rear_value  = is_empty ? '1 : rear_q;
    assign o_empty_flag  = is_empty;
    assign o_full_flag   = is_full;
    assign o_occupancy   = r_count;

endmodule

/* hw/rtl/circular_double_ended_queue_top.sv */
// A request accepted at a clock edge has its result word on the result
// ports, marked by o_strobe, in the respond step after the slot read.
// A new request is taken only once the execute, slot read and respond
// steps of the controller are done; busy is high until then.
// Reset (i_rst_n low, synchronous) empties the deque and sets capacity to 16;
// the slot memory is not cleared. The receiver cannot stall the result word.
// ----------------------------------------------------------------------------
// Circular double-ended queue
// A bounded ring-buffer deque with a programmable capacity. Each request
// inserts or deletes at either end and returns the state after the operation.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: capacity register, written whenever the enable is high.
    input  logic                  i_cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0] i_cfg_wdata,
    // Request word, taken when start is high and busy is low.
    input  logic                  start,
    output logic                  busy,
    input  logic [cdq_pkg::REQ_W-1:0] i_req_type,
    input  logic signed [cdq_pkg::VAL_W-1:0] i_value,
    // Result word, valid for the single cycle in which o_strobe is high.
    output logic                  o_strobe,
    output logic                  o_accepted,
    output logic signed [cdq_pkg::VAL_W-1:0] o_front_value,
    output logic signed [cdq_pkg::VAL_W-1:0] o_rear_value,
    output logic                  o_empty_flag,
    output logic                  o_full_flag,
    output logic [cdq_pkg::CNT_W-1:0] o_occupancy
);

    import cdq_pkg::*;

    // Command bundle from the sequencer to the datapath.
    t_dp_cmd cmd;

    // The controller accepts a request in its idle state and tells the
    // datapath to execute it at once; the ends are read in the next cycle
    // and the registered read data forms the result in the cycle after.
    cdq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    // The datapath keeps the pointers, the count and the capacity, writes
    // the inserted word into its slot and presents the front and rear words.
    cdq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .o_accepted    (o_accepted),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_empty_flag  (o_empty_flag),
        .o_full_flag   (o_full_flag),
        .o_occupancy   (o_occupancy)
    );

endmodule
